>>> hw/rtl/i2da_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_pkg: shared constants and types for the integer to decimal ASCII unit
// Sizes of the value and digit stores, the format commands and the character
// codes that the unit emits.
// ----------------------------------------------------------------------------
package i2da_pkg;

    // Value and digit store sizes
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 20;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 64;
    localparam int CHAR_W = 6;

    // Derived sizes
    localparam int BCD_W  = 4 * MAX_DIGITS;
    localparam int BITS_W = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W  = $clog2(MAX_DIGITS + 1);

    // Format command bits
    localparam int CMD_BIT_WIDE   = 0;
    localparam int CMD_BIT_SIGNED = 1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_SIGN = 5'b00100,
        S_SKIP = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/i2da_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_in_if: input channel of the integer to decimal ASCII unit
// Carries one format command and one raw value per beat.
// ----------------------------------------------------------------------------
interface i2da_in_if;
    import i2da_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface
`default_nettype wire

>>> hw/rtl/i2da_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2da_out_if: output channel of the integer to decimal ASCII unit
// Carries one ASCII character and its end-of-number flag per beat.
// ----------------------------------------------------------------------------
interface i2da_out_if;
    import i2da_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);

endinterface
`default_nettype wire

>>> hw/rtl/integer_to_decimal_ascii_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit: integer to decimal ASCII converter
// Converts a 32- or 64-bit, signed or unsigned value to its decimal ASCII
// characters, most significant digit first, by bit-serial double dabble.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                    beat
//  i_in     in   command[1:0], value[63:0]  one number to print
//  o_out    out  char_code[5:0], last_char  one character, last flags the end
//
//  A number takes a load step, VALUE_WIDTH (64) double dabble shifts at one
//  bit per cycle, a sign step, then a skip step that drops leading zeros one
//  per cycle and an emit step that sends one digit per cycle while the sink
//  does not stall. A new number is taken only once the last digit is sent.
//  i_in.ready is high only while no number is in work; the last character
//  may still wait in the output register when the next number is taken.
//  A stalled sink holds the sequencer in the sign or emit step.
//  Reset (synchronous, active low) empties the output register and idles.
//
module integer_to_decimal_ascii_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    i2da_in_if.sink      i_in,
    i2da_out_if.source   o_out
);
    import i2da_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_bin,   n_bin;
    logic [BCD_W-1:0]       r_bcd,   n_bcd;
    logic [BITS_W-1:0]      r_bits,  n_bits;
    logic [REM_W-1:0]       r_rem,   n_rem;
    logic                   r_neg,   n_neg;
    logic                   r_ovf,   n_ovf;
    logic                   r_ov,    n_ov;
    logic [CHAR_W-1:0]      r_char,  n_char;
    logic                   r_last,  n_last;

    logic                   w_accept;
    logic                   w_free;
    logic                   w_wide;
    logic [VALUE_WIDTH-1:0] w_mask;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   w_sign;
    logic [BCD_W-1:0]       w_adj;
    logic [3:0]             w_top;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_free   = !r_ov || o_out.ready;
    assign w_top    = r_bcd[BCD_W-1 -: 4];

    // Mask the value to the mode width and find its sign
    assign w_wide = i_in.command[CMD_BIT_WIDE];
    assign w_mask = w_wide ? {VALUE_WIDTH{1'b1}}
                           : {{(VALUE_WIDTH-32){1'b0}}, {32{1'b1}}};
    assign w_val  = i_in.value[VALUE_WIDTH-1:0] & w_mask;
    assign w_sign = i_in.command[CMD_BIT_SIGNED] &&
                    (w_wide ? w_val[VALUE_WIDTH-1] : w_val[31]);

    // Add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            w_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                        : r_bcd[4*d +: 4];
        end
    end

    // Sequence the load, shift, sign, skip and emit steps
    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_bits  = r_bits;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_ov    = r_ov && !o_out.ready;
        n_char  = r_char;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = w_sign;
                    n_bin   = w_sign ? ((VALUE_WIDTH'(0) - w_val) & w_mask) : w_val;
                    n_bcd   = '0;
                    n_ovf   = 1'b0;
                    n_bits  = BITS_W'(VALUE_WIDTH);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin  = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_ovf  = r_ovf || w_adj[BCD_W-1];
                n_bits = r_bits - BITS_W'(1);
                n_rem  = REM_W'(MAX_DIGITS);
                if (r_bits == BITS_W'(1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (!r_neg) begin
                    n_state = S_SKIP;
                end else if (w_free) begin
                    n_ov    = 1'b1;
                    n_char  = CH_MINUS;
                    n_last  = 1'b0;
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, keeping at least one digit
                if (w_top == 4'd0 && r_rem > REM_W'(1) && !r_ovf) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_rem = r_rem - REM_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_free) begin
                    n_ov   = 1'b1;
                    n_char = CH_ZERO + CHAR_W'(w_top);
                    n_last = (r_rem == REM_W'(1));
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_rem  = r_rem - REM_W'(1);
                    if (r_rem == REM_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ov;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    // Checks on the sequencer
    a_load_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV) && (r_bits == BITS_W'(VALUE_WIDTH)))
        else $error("accepted number did not start the shift loop");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_code == CH_MINUS) |-> !o_out.last_char)
        else $error("minus sign flagged as last character");

    a_last_digit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_free && r_rem == REM_W'(1)) |=>
            (r_state == S_IDLE) && o_out.valid && o_out.last_char)
        else $error("last digit did not end the number");

endmodule
`default_nettype wire
